@@ design/fsmf_pkg.sv @@
// ----------------------------------------------------------------------------
// fsmf_pkg
// Shared types and constants for the first substring match finder: the item
// action codes, default sizes and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package fsmf_pkg;

   // default sizes
   localparam int MAX_NEEDLE_DEF    = 256;
   localparam int POSITION_BITS_DEF = 32;

   // fixed item field widths
   localparam int ACTION_W   = 2;
   localparam int BYTE_W     = 8;
   localparam int POS_OUT_W  = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // what an input item asks for
   typedef enum logic [ACTION_W-1:0] {
      ACT_BEGIN    = 2'd0,
      ACT_APPEND   = 2'd1,
      ACT_HAYSTACK = 2'd2,
      ACT_END      = 2'd3
   } action_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic              clear;
      logic              load;
      logic              step;
      logic [BYTE_W-1:0] data;
   } cell_ctl_type;

endpackage

@@ design/fsmf_cell.sv @@
// ----------------------------------------------------------------------------
// fsmf_cell
// One cell of the matching chain. It holds one needle byte, an occupied flag
// and the partial match bit of the needle prefix that ends at its byte.
// Needle bytes enter at cell 0 and shift upward, so cell 0 always holds the
// last needle byte and its partial bit is the full-needle match.
// ----------------------------------------------------------------------------
module fsmf_cell
   import fsmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   // from the lower neighbor (load shift)
   input  logic [BYTE_W-1:0] low_byte,
   input  logic              low_occ,
   // from the upper neighbor (shorter prefix)
   input  logic              up_occ,
   input  logic              up_pm,
   // to the neighbors
   output logic [BYTE_W-1:0] byte_out,
   output logic              occ_out,
   output logic              pm_out,
   // full-prefix result for this step
   output logic              match
);

   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              occ_ff, occ_in;
   logic              pm_ff, pm_in;
   logic              prev;

   // the top occupied cell holds needle byte 0 and has no prefix before it
   assign prev  = up_occ ? up_pm : 1'b1;
   assign match = occ_ff && prev && (byte_ff == ctl.data);

   // next state; most cycles carry no control and keep the cell as it is
   always_comb begin
      byte_in = byte_ff;
      occ_in  = occ_ff;
      pm_in   = pm_ff;
      if (ctl.clear) begin
         occ_in = 1'b0;
         pm_in  = 1'b0;
      end else if (ctl.load) begin
         byte_in = low_byte;
         occ_in  = low_occ;
      end else if (ctl.step) begin
         pm_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
         pm_ff  <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         pm_ff  <= pm_in;
      end
   end

   // needle byte needs no reset: unoccupied cells never match
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign byte_out = byte_ff;
   assign occ_out  = occ_ff;
   assign pm_out   = pm_ff;

endmodule

@@ design/first_substring_match_finder_top.sv @@
// ----------------------------------------------------------------------------
// first_substring_match_finder_top
// Loads a needle into a chain of byte cells, then scans a haystack one byte
// per item and reports where the needle first occurs, or that it does not.
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata               tuser
//   req      in   data_byte [7:0]     action [1:0]
//   rsp      out  position [31:0]     found [0], needle_too_long [1]
//
// All cells compare the haystack byte at once and the match ripples one cell
// per item, so one byte is taken per clock while no result is held.
// A result is held in the output register; the next item is taken in the
// same cycle that the result leaves, and waits only while it is held.
// Synchronous reset clears the needle, the search state and the output valid.
// Begin new search clears the chain.
// ----------------------------------------------------------------------------
module first_substring_match_finder_top
   import fsmf_pkg::*;
#(
   parameter int MAX_NEEDLE    = MAX_NEEDLE_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // data_byte [7:0]
   input  logic [ACTION_W-1:0]   req_tuser,  // action [1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // position [31:0]
   output logic [RSP_USER_W-1:0] rsp_tuser   // found [0], needle_too_long [1]
);

   localparam int COUNT_W = $clog2(MAX_NEEDLE + 1);
   localparam int DIFF_W  = (POSITION_BITS > COUNT_W) ? POSITION_BITS : COUNT_W;

   // search state
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [POSITION_BITS-1:0] index_ff, index_in;
   logic                     done_ff, done_in;
   logic                     ovf_ff, ovf_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 found_ff, found_in;
   logic                 ntl_ff, ntl_in;
   logic [POS_OUT_W-1:0] pos_ff, pos_in;

   logic         req_fire;
   action_type   action;
   logic [BYTE_W-1:0] data_byte;
   cell_ctl_type ctl;
   logic         hit;

   // chain wiring
   logic [BYTE_W-1:0] cell_byte [MAX_NEEDLE];
   logic              cell_occ  [MAX_NEEDLE];
   logic              cell_pm   [MAX_NEEDLE];
   logic              cell_match[MAX_NEEDLE];

   // start index of a hit
   logic [COUNT_W-1:0]            span;
   logic [DIFF_W-1:0]             cur_ext, span_ext, start;
   logic [DIFF_W+POS_OUT_W-1:0]   start_ext;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign action     = action_type'(req_tuser);
   assign data_byte  = req_tdata[BYTE_W-1:0];

   // cell 0 holds the last needle byte, so its match is the full needle
   assign hit = cell_match[0];

   assign span      = count_ff - COUNT_W'(1);
   assign cur_ext   = DIFF_W'(index_ff);
   assign span_ext  = DIFF_W'(span);
   assign start     = (cur_ext >= span_ext) ? (cur_ext - span_ext) : '0;
   assign start_ext = (DIFF_W+POS_OUT_W)'(start);

   // item decode and search control
   always_comb begin
      count_in     = count_ff;
      index_in     = index_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      ntl_in       = ntl_ff;
      pos_in       = pos_ff;
      ctl.clear    = 1'b0;
      ctl.load     = 1'b0;
      ctl.step     = 1'b0;
      ctl.data     = data_byte;
      if (req_fire) begin
         unique case (action)
            ACT_BEGIN: begin
               ctl.clear = 1'b1;
               count_in  = '0;
               index_in  = '0;
               done_in   = 1'b0;
               ovf_in    = 1'b0;
            end
            ACT_APPEND: begin
               if (data_byte != '0 && !done_ff && index_ff == '0) begin
                  if (count_ff < COUNT_W'(MAX_NEEDLE)) begin
                     ctl.load = 1'b1;
                     count_in = count_ff + COUNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            ACT_HAYSTACK, ACT_END: begin
               if (!done_ff) begin
                  priority if (action == ACT_END || data_byte == '0) begin
                     // haystack end: only an empty needle has matched
                     rsp_valid_in = 1'b1;
                     found_in     = (count_ff == '0) && !ovf_ff;
                     pos_in       = '0;
                     ntl_in       = ovf_ff;
                     done_in      = 1'b1;
                  end else if (count_ff == '0 && !ovf_ff) begin
                     // empty needle matches at the start
                     rsp_valid_in = 1'b1;
                     found_in     = 1'b1;
                     pos_in       = '0;
                     ntl_in       = 1'b0;
                     done_in      = 1'b1;
                  end else begin
                     ctl.step = !ovf_ff;
                     if (index_ff != '1) begin
                        index_in = index_ff + POSITION_BITS'(1);
                     end
                     if (!ovf_ff && hit) begin
                        rsp_valid_in = 1'b1;
                        found_in     = 1'b1;
                        pos_in       = start_ext[POS_OUT_W-1:0];
                        ntl_in       = 1'b0;
                        done_in      = 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         index_ff     <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         index_ff     <= index_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      found_ff <= found_in;
      ntl_ff   <= ntl_in;
      pos_ff   <= pos_in;
   end

   // chain of cells
   for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
      logic [BYTE_W-1:0] low_byte;
      logic              low_occ;
      logic              up_occ;
      logic              up_pm;

      if (j == 0) begin : g_first
         assign low_byte = data_byte;
         assign low_occ  = 1'b1;
      end else begin : g_mid
         assign low_byte = cell_byte[j-1];
         assign low_occ  = cell_occ[j-1];
      end

      if (j == MAX_NEEDLE - 1) begin : g_last
         assign up_occ = 1'b0;
         assign up_pm  = 1'b0;
      end else begin : g_inner
         assign up_occ = cell_occ[j+1];
         assign up_pm  = cell_pm[j+1];
      end

      fsmf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .low_byte (low_byte),
         .low_occ  (low_occ),
         .up_occ   (up_occ),
         .up_pm    (up_pm),
         .byte_out (cell_byte[j]),
         .occ_out  (cell_occ[j]),
         .pm_out   (cell_pm[j]),
         .match    (cell_match[j])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(pos_ff);
   assign rsp_tuser  = {ntl_ff, found_ff};

   // a pending result always belongs to a finished search
   a_done_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> done_ff)
      else $error("result pending while search not done");

   // cell 0 is occupied exactly when the needle is not empty
   a_occ_matches_count: assert property (@(posedge clock) disable iff (reset)
      cell_occ[0] == (count_ff != '0))
      else $error("chain occupancy disagrees with needle count");

   // the needle count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_NEEDLE))
      else $error("needle count beyond store depth");

   // overflow only happens with a full store
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == COUNT_W'(MAX_NEEDLE)))
      else $error("overflow flagged with store not full");

endmodule
